### src/buddy_block_allocator_assert.svh
// assertion macros for the buddy block allocator checker
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// checked on every clock edge out of reset
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/bba_pkg.sv
// types and constants shared by the buddy block allocator modules
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned OrderW        = 5;
  localparam int unsigned SizeW         = 21;
  localparam int unsigned WasteW        = 20;
  localparam int unsigned IdW           = 8;
  localparam int unsigned MemOrderReset = 10;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoFit     = 3'd1,
    StSizeZero  = 3'd2,
    StIdBusy    = 3'd3,
    StIdNotHeld = 3'd4
  } status_e;

  typedef struct packed {
    logic              op;
    logic [IdW-1:0]    proc_id;
    logic [SizeW-1:0]  req_size;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [2:0]        status;
    logic [OrderW-1:0] block_order;
    logic [WasteW-1:0] internal_waste;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [OrderW-1:0] order;
  } owner_t;

  typedef struct packed {
    logic   en;
    owner_t entry;
  } owner_wr_t;

endpackage

`default_nettype wire

### src/bba_owner_ram.sv
// owner table: synchronous memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bba_owner_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire bba_pkg::owner_t          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output bba_pkg::owner_t               rdata_o
);

  bba_pkg::owner_t mem_q [DEPTH];
  bba_pkg::owner_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bba_engine.sv
// free map store and the allocate / release decision
`timescale 1ns / 1ps
`default_nettype none

module bba_engine #(
  parameter int unsigned MAX_ORDER = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bba_pkg::OrderW-1:0]    cfg_wdata_i,
  input  wire bba_pkg::req_t                 req_i,
  input  wire logic                          in_table_i,
  input  wire bba_pkg::owner_t               entry_i,
  input  wire logic                          commit_i,
  output bba_pkg::rsp_t                      rsp_o,
  output bba_pkg::owner_wr_t                 owner_wr_o
);

  localparam int unsigned MapW = MAX_ORDER + 1;
  localparam logic [bba_pkg::OrderW-1:0] MemOrderRst =
    bba_pkg::OrderW'((bba_pkg::MemOrderReset > MAX_ORDER) ? MAX_ORDER
                                                          : bba_pkg::MemOrderReset);

  logic [bba_pkg::OrderW-1:0] mem_order_q;
  logic [bba_pkg::OrderW-1:0] cfg_sat;
  logic [MapW-1:0]            free_q;
  logic [MapW-1:0]            free_d;
  logic                       map_wr;

  logic [bba_pkg::SizeW-1:0]  size_m1;
  logic [bba_pkg::SizeW-1:0]  s1;
  logic [bba_pkg::SizeW-1:0]  s2;
  logic [bba_pkg::SizeW-1:0]  s4;
  logic [bba_pkg::SizeW-1:0]  s8;
  logic [bba_pkg::SizeW-1:0]  below;
  logic [bba_pkg::SizeW:0]    pow;
  logic [bba_pkg::OrderW-1:0] need;

  logic [MapW-1:0]            below_m;
  logic [MapW-1:0]            pow_m;
  logic [MapW-1:0]            limit_m;
  logic [MapW-1:0]            cand;
  logic [MapW-1:0]            low;
  logic                       fit;
  logic [MapW-1:0]            alloc_map;
  logic [MapW-1:0]            release_map;
  logic [bba_pkg::WasteW-1:0] waste;

  function automatic logic [bba_pkg::OrderW-1:0] pow_to_order(
    input logic [bba_pkg::SizeW:0] p
  );
    logic [bba_pkg::OrderW-1:0] o;
    o = '0;
    for (int i = 0; i <= bba_pkg::SizeW; i++) begin
      if (p[i]) o = o | bba_pkg::OrderW'(i);
    end
    return o;
  endfunction

  assign cfg_sat = (32'(cfg_wdata_i) > MAX_ORDER) ? bba_pkg::OrderW'(MAX_ORDER)
                                                  : cfg_wdata_i;

  // round the request up to a power of two by smearing size-1 downward
  assign size_m1 = req_i.req_size - bba_pkg::SizeW'(1);
  assign s1      = size_m1 | (size_m1 >> 1);
  assign s2      = s1 | (s1 >> 2);
  assign s4      = s2 | (s2 >> 4);
  assign s8      = s4 | (s4 >> 8);
  assign below   = s8 | (s8 >> 16);
  assign pow     = {1'b0, below} + (bba_pkg::SizeW + 1)'(1);
  assign need    = pow_to_order(pow);

  // smallest free order at or above need, then split down
  assign below_m   = MapW'(below);
  assign pow_m     = below_m + MapW'(1);
  assign limit_m   = ~({MapW{1'b1}} << mem_order_q) | (MapW'(1) << mem_order_q);
  assign cand      = free_q & ~below_m & limit_m;
  assign low       = cand & (~cand + MapW'(1));
  assign fit       = |cand;
  assign alloc_map = (free_q & ~low) | (low - pow_m);

  // release adds the block back, carries merge buddies
  assign release_map = free_q + (MapW'(1) << entry_i.order);

  assign waste = bba_pkg::WasteW'(pow - {1'b0, req_i.req_size});

  always_comb begin
    rsp_o                  = '0;
    rsp_o.status           = bba_pkg::StOk;
    owner_wr_o             = '0;
    free_d                 = free_q;
    map_wr                 = 1'b0;
    if (req_i.op == bba_pkg::OpFree) begin
      if (!in_table_i || !entry_i.valid) begin
        rsp_o.status = bba_pkg::StIdNotHeld;
      end else begin
        rsp_o.ok          = 1'b1;
        rsp_o.block_order = entry_i.order;
        owner_wr_o.en     = 1'b1;
        free_d            = release_map;
        map_wr            = 1'b1;
      end
    end else begin
      if (req_i.req_size == '0) begin
        rsp_o.status = bba_pkg::StSizeZero;
      end else if (!in_table_i || entry_i.valid) begin
        rsp_o.status = bba_pkg::StIdBusy;
      end else if ((need > mem_order_q) || !fit) begin
        rsp_o.status = bba_pkg::StNoFit;
      end else begin
        rsp_o.ok             = 1'b1;
        rsp_o.block_order    = need;
        rsp_o.internal_waste = waste;
        owner_wr_o.en        = 1'b1;
        owner_wr_o.entry     = '{valid: 1'b1, order: need};
        free_d               = alloc_map;
        map_wr               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_order_q <= MemOrderRst;
      free_q      <= MapW'(1) << MemOrderRst;
    end else if (cfg_we_i) begin
      mem_order_q <= cfg_sat;
      free_q      <= MapW'(1) << cfg_sat;
    end else if (commit_i && map_wr) begin
      free_q      <= free_d;
    end
  end

endmodule

`default_nettype wire

### src/buddy_block_allocator.sv
// buddy block allocator top level: sequencer, owner table and free map
`timescale 1ns / 1ps
`default_nettype none

// Each transaction first reads the owner entry of proc_id from the synchronous owner table,
// then, in the lookup state, decides, writes the entry back and updates the free map.
// A result is held in an output register, so the next transaction can be taken while a
// result still waits; the decision cycle itself waits while that register holds a stalled
// result. After reset and after every write of mem_order the owner table is swept clear,
// one entry per cycle, through all PROC_SLOTS entries; in_stall_o stays high meanwhile.
module buddy_block_allocator #(
  parameter int unsigned MAX_ORDER  = 20,
  parameter int unsigned PROC_SLOTS = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bba_pkg::OrderW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire bba_pkg::req_t              in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bba_pkg::rsp_t                   out_rsp_o
);

  localparam int unsigned IdxW = $clog2(PROC_SLOTS);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     clr_cnt_q;
  logic [IdxW-1:0]     idx_q;
  logic                in_table_q;
  bba_pkg::req_t       req_q;
  logic                out_valid_q;
  bba_pkg::rsp_t       out_q;

  logic [31:0]         id_ext;
  logic                in_table;
  logic                in_acc;
  logic                out_free;
  logic                commit;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  bba_pkg::owner_t     ram_wdata;
  bba_pkg::owner_t     ram_rdata;

  bba_pkg::rsp_t       rsp;
  bba_pkg::owner_wr_t  owner_wr;

  assign id_ext   = 32'(in_req_i.proc_id);
  assign in_table = id_ext < PROC_SLOTS;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == StLookup) && out_free && !cfg_we_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = owner_wr.entry;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (commit && owner_wr.en && in_table_q) begin
      ram_we    = 1'b1;
    end
  end

  bba_owner_ram #(
    .DEPTH(PROC_SLOTS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (id_ext[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  bba_engine #(
    .MAX_ORDER(MAX_ORDER)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_q),
    .in_table_i  (in_table_q),
    .entry_i     (ram_rdata),
    .commit_i    (commit),
    .rsp_o       (rsp),
    .owner_wr_o  (owner_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      idx_q       <= '0;
      in_table_q  <= 1'b0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        state_q   <= StClear;
        clr_cnt_q <= '0;
      end else begin
        case (state_q)
          StClear: begin
            clr_cnt_q <= clr_cnt_q + IdxW'(1);
            if (clr_cnt_q == IdxW'(PROC_SLOTS - 1)) begin
              state_q <= StIdle;
            end
          end
          StIdle: begin
            if (in_acc) begin
              req_q      <= in_req_i;
              idx_q      <= id_ext[IdxW-1:0];
              in_table_q <= in_table;
              state_q    <= StLookup;
            end
          end
          StLookup: begin
            if (commit) begin
              out_q   <= rsp;
              state_q <= StIdle;
            end
          end
          default: begin
            state_q <= StClear;
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

### src/bba_checker.sv
// port-level checks for the buddy block allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "buddy_block_allocator_assert.svh"

module bba_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire bba_pkg::rsp_t out_rsp_o
);

  `BBA_ASSERT(ok_matches_status, out_valid_o |-> (out_rsp_o.ok == (out_rsp_o.status == bba_pkg::StOk)), "ok flag disagrees with status")
  `BBA_ASSERT(error_fields_zero, (out_valid_o && !out_rsp_o.ok) |-> (out_rsp_o.block_order == '0 && out_rsp_o.internal_waste == '0), "failed transaction carries order or waste")
  `BBA_ASSERT(out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)), "stalled result changed")
  `BBA_ASSERT(one_in_flight, (in_valid_i && !in_stall_o) |=> in_stall_o, "second transaction taken while one is in flight")
  `BBA_ASSERT_ALWAYS(reset_quiet, !rst_ni |-> (!out_valid_o && in_stall_o), "ports active during reset")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
